FILE: rtl/voice_steal_allocator_macros.svh
// Assertion macros used by the voice allocator module.
`ifndef VOICE_STEAL_ALLOCATOR_MACROS_SVH
`define VOICE_STEAL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("voice allocator check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("voice allocator check failed");

`endif

FILE: rtl/vsa_pkg.sv
// Types and constants shared by the voice allocator modules.
package vsa_pkg;

  localparam int unsigned VoiceCountDefault = 32;
  localparam int unsigned HIdxW             = 9;
  localparam int unsigned PrioWeight        = 256;

  localparam logic [31:0] ScoreAbsent = 32'h4000_0000;
  localparam logic [31:0] ScoreFloor  = 32'hC000_0000;
  localparam logic [31:0] GenStep     = 32'd512;
  localparam int unsigned IdleBonusShift = 27;

  typedef enum logic [1:0] {
    CmdAlloc  = 2'd0,
    CmdStatus = 2'd1,
    CmdQuery  = 2'd2,
    CmdStop   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PlayIdle    = 2'd0,
    PlayPlaying = 2'd1,
    PlayLooping = 2'd2
  } play_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StCommit,
    StLookup,
    StCheck,
    StStatus
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ticks;
    logic signed [31:0] priority_req;
    logic [7:0]  sample_index;
    logic [31:0] voice_handle;
    logic [4:0]  voice_select;
    logic        is_playing;
    logic        is_looping;
    logic        is_present;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  chosen_voice;
    logic [31:0] new_handle;
    logic        recycled;
    logic        handle_valid;
    logic [1:0]  play_state;
  } out_item_t;

  typedef struct packed {
    logic present;
    logic playing;
    logic looping;
  } voice_flags_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] start_time;
    logic [31:0] prio;
    logic [7:0]  sample;
  } voice_rec_t;

  // What the scorer hands back for one voice.
  typedef struct packed {
    logic [31:0] score;
    logic [31:0] tag;
  } scored_t;

endpackage

FILE: rtl/voice_steal_allocator.sv
// Voice allocator with priority- and age-based stealing over a pool of playback voices.
// Allocate reads each voice in turn, drains the scorer, then commits.
// Query and stop read the addressed voice, then check it; a status write needs no read; one item at a time.
// Allocate time is set by the single read port of the voice memories, walked once per allocate.
// A result waits in an output register while the next beat is taken in.
// Reset empties the pool at once through per-entry written bits; no clearing pass.
module voice_steal_allocator #(
  parameter int unsigned VoiceCount = vsa_pkg::VoiceCountDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vsa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vsa_pkg::out_item_t out_data_o
);
  import vsa_pkg::*;

  `include "voice_steal_allocator_macros.svh"

  localparam int unsigned IdxW    = $clog2(VoiceCount);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VoiceCount - 1);
  localparam int unsigned FlagW   = $bits(voice_flags_t);
  localparam int unsigned RecW    = $bits(voice_rec_t);

  state_e          state_q, state_d;
  in_item_t        item_q;
  logic [IdxW-1:0] cnt_q, cnt_d;

  logic            out_valid_q;
  out_item_t       out_q, out_d;
  logic            out_load;
  logic            out_free;
  logic            accept;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            flag_wr_en;
  logic            rec_wr_en;
  logic [IdxW-1:0] wr_addr;
  voice_flags_t    flag_wr_data;
  voice_rec_t      rec_wr_data;
  logic [FlagW-1:0] flag_rd_raw;
  logic [RecW-1:0]  rec_rd_raw;
  voice_flags_t    flag_rd;
  voice_rec_t      rec_rd;

  logic            scan_pend_q;
  logic [IdxW-1:0] scan_idx_q;
  logic            sc_vld;
  logic [IdxW-1:0] sc_idx;
  scored_t         sc_res;

  logic            found_q;
  logic [31:0]     best_score_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_tag_q;
  logic [31:0]     tag0_q;
  logic            take_best;

  logic [HIdxW-1:0] hidx;
  logic             h_in_range;
  logic             h_ok;
  logic [HIdxW-1:0] sel_ext;
  logic             sel_ok;
  logic [HIdxW-1:0] best_idx_ext;
  logic [31:0]      new_tag;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  vsa_mem #(.Depth(VoiceCount), .Width(FlagW), .AddrW(IdxW)) u_flag_mem (
    .clk_i,
    .rst_ni,
    .wr_en_i   (flag_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (flag_wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (flag_rd_raw)
  );

  vsa_mem #(.Depth(VoiceCount), .Width(RecW), .AddrW(IdxW)) u_rec_mem (
    .clk_i,
    .rst_ni,
    .wr_en_i   (rec_wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (rec_wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rec_rd_raw)
  );

  assign flag_rd = voice_flags_t'(flag_rd_raw);
  assign rec_rd  = voice_rec_t'(rec_rd_raw);

  vsa_score #(.IdxW(IdxW)) u_score (
    .clk_i,
    .rst_ni,
    .vld_i   (scan_pend_q),
    .idx_i   (scan_idx_q),
    .flags_i (flag_rd),
    .rec_i   (rec_rd),
    .now_i   (item_q.now_ticks),
    .prio_i  (item_q.priority_req),
    .vld_o   (sc_vld),
    .idx_o   (sc_idx),
    .res_o   (sc_res)
  );

  // Handle and select decoding.
  assign hidx         = item_q.voice_handle[HIdxW-1:0];
  assign h_in_range   = 32'(hidx) < VoiceCount;
  assign h_ok         = h_in_range && flag_rd.present &&
                        (item_q.voice_handle[31:HIdxW] == rec_rd.tag[31:HIdxW]);
  assign sel_ext      = HIdxW'(item_q.voice_select);
  assign sel_ok       = 32'(sel_ext) < VoiceCount;
  assign best_idx_ext = HIdxW'(best_idx_q);
  assign new_tag      = {best_tag_q[31:HIdxW], best_idx_ext} + GenStep;

  // Later voices win ties, hence the greater-or-equal.
  assign take_best = sc_vld && ($signed(sc_res.score) >= $signed(best_score_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      scan_pend_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_pend_q <= (state_q == StScan);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        found_q <= 1'b0;
      end else if (take_best) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    scan_idx_q <= rd_addr;
    if (accept) begin
      best_score_q <= ScoreFloor;
    end else if (take_best) begin
      best_score_q <= sc_res.score;
      best_idx_q   <= sc_idx;
      best_tag_q   <= sc_res.tag;
    end
    if (sc_vld && sc_idx == '0) begin
      tag0_q <= sc_res.tag;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_en        = 1'b0;
    rd_addr      = cnt_q;
    flag_wr_en   = 1'b0;
    rec_wr_en    = 1'b0;
    wr_addr      = best_idx_q;
    flag_wr_data = '0;
    rec_wr_data  = '0;
    out_load     = 1'b0;
    out_d        = '0;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept) begin
          case (in_data_i.command)
            CmdAlloc:  state_d = StScan;
            CmdStatus: state_d = StStatus;
            default:   state_d = StLookup;
          endcase
        end
      end
      StScan: begin
        rd_en = 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDrain: begin
        if (sc_vld && sc_idx == LastIdx) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        rec_wr_data.tag        = new_tag;
        rec_wr_data.start_time = item_q.now_ticks;
        rec_wr_data.prio       = item_q.priority_req;
        rec_wr_data.sample     = item_q.sample_index;
        if (out_free) begin
          out_load = 1'b1;
          // Recycling also releases the voice until the engine reports again.
          flag_wr_en = found_q;
          rec_wr_en  = found_q;
          out_d.chosen_voice = found_q ? best_idx_ext[4:0] : 5'd0;
          out_d.new_handle   = found_q ? new_tag : tag0_q;
          out_d.recycled     = found_q;
          state_d = StIdle;
        end
      end
      StLookup: begin
        rd_en   = 1'b1;
        rd_addr = hidx[IdxW-1:0];
        state_d = StCheck;
      end
      StCheck: begin
        wr_addr = hidx[IdxW-1:0];
        flag_wr_data.present = flag_rd.present;
        if (out_free) begin
          out_load = 1'b1;
          flag_wr_en = h_ok && (item_q.command == CmdStop);
          out_d.chosen_voice = h_in_range ? hidx[4:0] : 5'd0;
          out_d.handle_valid = h_ok;
          if (h_ok && item_q.command == CmdQuery) begin
            if (flag_rd.looping) begin
              out_d.play_state = PlayLooping;
            end else if (flag_rd.playing) begin
              out_d.play_state = PlayPlaying;
            end else begin
              out_d.play_state = PlayIdle;
            end
          end
          state_d = StIdle;
        end
      end
      StStatus: begin
        wr_addr = sel_ext[IdxW-1:0];
        flag_wr_data.present = item_q.is_present;
        flag_wr_data.playing = item_q.is_playing;
        flag_wr_data.looping = item_q.is_looping;
        if (out_free) begin
          out_load   = 1'b1;
          flag_wr_en = sel_ok;
          out_d.chosen_voice = item_q.voice_select;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VSA_ASSERT_NOW(a_rec_write_only_when_found, rec_wr_en, found_q && out_load)
  `VSA_ASSERT_NEXT(a_busy_after_accept, accept, in_stall_o)
  `VSA_ASSERT_NOW(a_score_only_while_allocating, sc_vld, state_q == StScan || state_q == StDrain)
  `VSA_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_o)

endmodule

FILE: rtl/vsa_mem.sv
// Synchronous voice memory with one write and one registered read port; unwritten entries read zero.
module vsa_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] written_q;
  logic [Width-1:0] rd_data_q;
  logic             rd_written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // An entry never written reads as zero.
  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

FILE: rtl/vsa_score.sv
// Two-stage pipeline that scores one voice per cycle for voice stealing.
module vsa_score #(
  parameter int unsigned IdxW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [IdxW-1:0]       idx_i,
  input  vsa_pkg::voice_flags_t flags_i,
  input  vsa_pkg::voice_rec_t   rec_i,
  input  logic [31:0]           now_i,
  input  logic [31:0]           prio_i,
  output logic                  vld_o,
  output logic [IdxW-1:0]       idx_o,
  output vsa_pkg::scored_t      res_o
);
  import vsa_pkg::*;

  localparam int unsigned CShift = $clog2(PrioWeight) + 1;

  logic            v1_q;
  logic [IdxW-1:0] idx1_q;
  logic            absent1_q;
  logic [1:0]      bonus1_q;
  logic [31:0]     d1_q;
  logic [31:0]     t1_q;
  logic [31:0]     tag1_q;

  logic            v2_q;
  logic [IdxW-1:0] idx2_q;
  scored_t         res2_q;
  scored_t         res2_d;

  logic signed [31:0] sh;
  logic signed [2:0]  c;
  logic [31:0]        c_ext;
  logic [31:0]        offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q    <= idx_i;
    absent1_q <= !flags_i.present;
    bonus1_q  <= 2'({1'b0, !flags_i.playing} + {1'b0, !flags_i.looping});
    d1_q      <= prio_i - rec_i.prio;
    t1_q      <= now_i - rec_i.start_time;
    tag1_q    <= rec_i.tag;
    idx2_q    <= idx1_q;
    res2_q    <= res2_d;
  end

  // The priority difference is clamped to two steps either way.
  always_comb begin
    sh = $signed(d1_q) >>> 2;
    if (sh > 32'sd1) begin
      c = 3'sd2;
    end else if (sh < -32'sd2) begin
      c = -3'sd2;
    end else begin
      c = sh[2:0];
    end
    c_ext  = {{29{c[2]}}, c};
    offset = (32'(bonus1_q) << IdleBonusShift) + (c_ext << CShift);
    res2_d.tag   = tag1_q;
    res2_d.score = absent1_q ? ScoreAbsent : ((t1_q << 1) + offset);
  end

  assign vld_o = v2_q;
  assign idx_o = idx2_q;
  assign res_o = res2_q;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the voice allocator: random and directed beats against a predictor.
import vsa_pkg::*;

localparam int          NVOICES   = VoiceCountDefault;
localparam logic [31:0] IdxMask   = (32'd1 << HIdxW) - 32'd1;
localparam logic [31:0] IdleBonus = 32'd1 << IdleBonusShift;

class voice_pool_scoreboard;
  bit          present [NVOICES];
  bit          playing [NVOICES];
  bit          looping [NVOICES];
  bit   [31:0] vtag    [NVOICES];
  bit   [31:0] vstart  [NVOICES];
  bit   [31:0] vprio   [NVOICES];
  bit   [7:0]  vsample [NVOICES];
  out_item_t   expected_results[$];
  int          errors;

  function int pending();
    return expected_results.size();
  endfunction

  // Steal score of one voice, wrapping 32-bit arithmetic read as signed.
  function logic signed [31:0] voice_score(int v, logic [31:0] now, logic [31:0] prio);
    logic        [31:0] base;
    logic        [31:0] diff;
    logic signed [31:0] steps;
    if (!present[v]) return ScoreAbsent;
    base = '0;
    if (!playing[v]) base += IdleBonus;
    if (!looping[v]) base += IdleBonus;
    diff  = prio - vprio[v];
    steps = $signed(diff) >>> 2;
    if (steps > 2) steps = 2;
    else if (steps < -2) steps = -2;
    return base + ((now + steps * 32'(PrioWeight) - vstart[v]) << 1);
  endfunction

  function out_item_t predict_result(in_item_t it);
    out_item_t          r;
    logic signed [31:0] best_score;
    logic signed [31:0] s;
    int unsigned        best;
    int unsigned        idx;
    bit                 found;
    bit                 ok;
    r = '0;
    case (cmd_e'(it.command))
      CmdAlloc: begin
        best       = 0;
        best_score = ScoreFloor;
        found      = 1'b0;
        // The later voice wins a tie, hence the greater-or-equal.
        for (int v = 0; v < NVOICES; v++) begin
          s = voice_score(v, it.now_ticks, it.priority_req);
          if (s >= best_score) begin
            best       = v;
            best_score = s;
            found      = 1'b1;
          end
        end
        if (found) begin
          vtag[best]    = ((vtag[best] & ~IdxMask) | (32'(best) & IdxMask)) + GenStep;
          present[best] = 1'b0;
          playing[best] = 1'b0;
          looping[best] = 1'b0;
          vstart[best]  = it.now_ticks;
          vprio[best]   = it.priority_req;
          vsample[best] = it.sample_index;
        end
        r.chosen_voice = 5'(best);
        r.new_handle   = vtag[best];
        r.recycled     = found;
      end
      CmdStatus: begin
        if (it.voice_select < NVOICES) begin
          playing[it.voice_select] = it.is_playing;
          looping[it.voice_select] = it.is_looping;
          present[it.voice_select] = it.is_present;
        end
        r.chosen_voice = it.voice_select;
      end
      default: begin
        idx = it.voice_handle & IdxMask;
        ok  = 1'b0;
        if (idx >= NVOICES) idx = 0;
        else ok = present[idx] && (((it.voice_handle ^ vtag[idx]) & ~IdxMask) == '0);
        r.chosen_voice = 5'(idx);
        r.handle_valid = ok;
        if (ok) begin
          if (it.command == CmdQuery) begin
            r.play_state = looping[idx] ? PlayLooping : (playing[idx] ? PlayPlaying : PlayIdle);
          end else begin
            playing[idx] = 1'b0;
            looping[idx] = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  function void note_command(in_item_t it);
    expected_results.push_back(predict_result(it));
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none actual %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("chosen_voice", 32'(want.chosen_voice), 32'(got.chosen_voice));
    compare_field("new_handle",   want.new_handle,        got.new_handle);
    compare_field("recycled",     32'(want.recycled),     32'(got.recycled));
    compare_field("handle_valid", 32'(want.handle_valid), 32'(got.handle_valid));
    compare_field("play_state",   32'(want.play_state),   32'(got.play_state));
  endfunction
endclass

module tb_top;
  localparam int RandomItems = 1700;
  localparam int CycleLimit  = 800000;
  localparam int DrainCycles = 60;
  localparam int HoldCycles  = 300;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  voice_pool_scoreboard sb = new();

  bit          quiet       = 1'b0;
  int          hold_asked  = 0;
  int          hold_served = 0;
  int          hold_left   = 0;
  int          cycles      = 0;
  logic [31:0] tick_base   = '0;

  voice_steal_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_command(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk_i) begin
    if (hold_served < hold_asked) begin
      hold_left = HoldCycles;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 35);
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.command      = 2'($urandom_range(3));
    it.now_ticks    = $urandom();
    it.priority_req = $urandom();
    it.sample_index = 8'($urandom());
    it.voice_handle = $urandom();
    it.voice_select = 5'($urandom());
    it.is_playing   = 1'($urandom());
    it.is_looping   = 1'($urandom());
    it.is_present   = 1'($urandom());
    return it;
  endfunction

  function automatic in_item_t mk_alloc(logic [31:0] now, logic [31:0] prio, logic [7:0] samp);
    in_item_t it;
    it              = noise_item();
    it.command      = CmdAlloc;
    it.now_ticks    = now;
    it.priority_req = prio;
    it.sample_index = samp;
    return it;
  endfunction

  function automatic in_item_t mk_status(logic [4:0] sel, logic pl, logic lp, logic pr);
    in_item_t it;
    it              = noise_item();
    it.command      = CmdStatus;
    it.voice_select = sel;
    it.is_playing   = pl;
    it.is_looping   = lp;
    it.is_present   = pr;
    return it;
  endfunction

  function automatic in_item_t mk_handle(cmd_e cmd, logic [31:0] h);
    in_item_t it;
    it              = noise_item();
    it.command      = cmd;
    it.voice_handle = h;
    return it;
  endfunction

  // Mostly handles that name a live tag; the rest stale, out of range or junk.
  function automatic logic [31:0] pick_handle();
    int unsigned v;
    int unsigned r;
    logic [31:0] h;
    v = $urandom_range(NVOICES - 1);
    r = $urandom_range(99);
    h = (sb.vtag[v] & ~IdxMask) | (32'(v) & IdxMask);
    if (r < 55) return h;
    if (r < 70) return h ^ (32'd1 << $urandom_range(31, HIdxW));
    if (r < 85) return (h & ~IdxMask) | (32'($urandom()) & IdxMask);
    return $urandom();
  endfunction

  function automatic in_item_t next_random_item();
    int unsigned r;
    int unsigned v;
    int          p;
    logic [31:0] now;
    logic [31:0] prio;
    r = $urandom_range(99);
    v = $urandom_range(NVOICES - 1);
    if (r < 25) begin
      case ($urandom_range(3))
        0, 1: begin
          tick_base += $urandom_range(5000);
          now = tick_base;
        end
        2:       now = sb.vstart[v] + 32'($urandom_range(4000));
        default: now = $urandom();
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          p    = int'($urandom_range(16)) - 8;
          prio = 32'(p);
        end
        4, 5, 6: begin
          p    = int'($urandom_range(24)) - 12;
          prio = sb.vprio[v] + 32'(p);
        end
        default: prio = $urandom();
      endcase
      return mk_alloc(now, prio, 8'($urandom()));
    end
    if (r < 60) begin
      return mk_status(5'($urandom()), 1'($urandom()), 1'($urandom()),
                       $urandom_range(99) < 75);
    end
    if (r < 80) return mk_handle(CmdQuery, pick_handle());
    return mk_handle(CmdStop, pick_handle());
  endfunction

  // Entered and left at a falling edge; the beat goes when stall is low at a rising edge.
  task automatic send_beat(input in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    while (!quiet && ($urandom_range(99) < 35)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_beat(mk_handle(CmdQuery, 32'h0000_0000));
    send_beat(mk_handle(CmdStop,  32'h0000_01FF));
    send_beat(mk_handle(CmdQuery, 32'hFFFF_FFFF));
    // An empty pool: every voice ties on the absent score, so the last one is taken.
    send_beat(mk_alloc(32'h0000_0000, 32'h7FFF_FFFF, 8'hFF));
    send_beat(mk_status(5'd31, 1'b1, 1'b0, 1'b1));
    send_beat(mk_handle(CmdQuery, sb.vtag[31]));
    send_beat(mk_status(5'd31, 1'b1, 1'b1, 1'b1));
    send_beat(mk_handle(CmdQuery, sb.vtag[31]));
    send_beat(mk_handle(CmdStop,  sb.vtag[31] ^ 32'h8000_0000));
    send_beat(mk_handle(CmdStop,  sb.vtag[31]));
    send_beat(mk_handle(CmdQuery, sb.vtag[31]));
    send_beat(mk_alloc(32'hFFFF_FFFF, 32'h8000_0000, 8'h00));
    // Fill the pool with busy voices so that a late allocate finds nothing worth stealing.
    for (int v = 0; v < NVOICES; v++) send_beat(mk_status(5'(v), 1'b1, 1'b1, 1'b1));
    send_beat(mk_alloc(32'h5000_0000, 32'h0000_0000, 8'h5A));
    send_beat(mk_alloc(32'h5000_0000, 32'h7FFF_FFFF, 8'hA5));
    send_beat(mk_alloc(32'h2000_0000, 32'h0000_0004, 8'h11));
    send_beat(mk_handle(CmdQuery, sb.vtag[0]));
    send_beat(mk_status(5'd0, 1'b0, 1'b0, 1'b0));

    for (int n = 0; n < RandomItems; n++) begin
      quiet = (n >= 600) && (n < 900);
      if (n == 300) hold_asked++;
      if (n == 1100) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (sb.pending() != 0);
      end
      send_beat(next_random_item());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
